// ----- hw/rtl/rlts_pkg.sv -----
// shared types and constants of the register list transfer sequencer
package rlts_pkg;

  // default depth of the request queue between front and back
  localparam int unsigned RltsQueueDepth = 2;

  // request mode codes
  typedef enum logic [1:0] {
    ModeStore       = 2'd0,
    ModeStorePredec = 2'd1,
    ModeLoad        = 2'd2,
    ModeLoadPostinc = 2'd3
  } mode_e;

  // back end sequencer states
  typedef enum logic {
    StIdle = 1'b0,
    StBusy = 1'b1
  } state_e;

  // classified request as it travels from front to back
  typedef struct packed {
    logic        predec;
    logic        to_mem;
    logic        wb;
    logic        sext;
    logic        is_long;
    logic [15:0] mask;
    logic [31:0] start;
    logic [31:0] final_addr;
  } req_t;

endpackage

// ----- hw/rtl/rlts_front.sv -----
// front end: classifies a request and works out its final address
module rlts_front import rlts_pkg::*; (
  input  logic [1:0]  mode_i,
  input  logic        is_long_i,
  input  logic [15:0] reg_mask_i,
  input  logic [31:0] start_address_i,
  output req_t        req_o
);

  // set bits in one nibble
  function automatic logic [2:0] nib_count(input logic [3:0] n);
    logic [2:0] c;
    c = 3'(n[0]) + 3'(n[1]) + 3'(n[2]) + 3'(n[3]);
    return c;
  endfunction

  logic [4:0] count;
  logic [6:0] bytes;
  mode_e      mode;

  // number of registers in the list
  assign count = 5'(nib_count(reg_mask_i[3:0]))  + 5'(nib_count(reg_mask_i[7:4]))
               + 5'(nib_count(reg_mask_i[11:8])) + 5'(nib_count(reg_mask_i[15:12]));

  // total bytes moved
  assign bytes = is_long_i ? {count, 2'b00} : {1'b0, count, 1'b0};

  // mode decode
  assign mode = mode_e'(mode_i);

  always_comb begin
    req_o.predec  = (mode == ModeStorePredec);
    req_o.to_mem  = (mode == ModeStore) || (mode == ModeStorePredec);
    req_o.wb      = (mode == ModeStorePredec) || (mode == ModeLoadPostinc);
    req_o.sext    = ((mode == ModeLoad) || (mode == ModeLoadPostinc)) && !is_long_i;
    req_o.is_long = is_long_i;
    req_o.mask    = reg_mask_i;
    req_o.start   = start_address_i;
    if (mode == ModeStorePredec) begin
      req_o.final_addr = start_address_i - {25'd0, bytes};
    end else begin
      req_o.final_addr = start_address_i + {25'd0, bytes};
    end
  end

endmodule

// ----- hw/rtl/rlts_queue.sv -----
// small request queue between front and back
module rlts_queue import rlts_pkg::*; #(
  parameter int unsigned Depth = RltsQueueDepth
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic wr_valid_i,
  output logic wr_ready_o,
  input  req_t wr_data_i,
  output logic rd_valid_o,
  input  logic rd_ready_i,
  output req_t rd_data_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  req_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            push, pop;

  assign wr_ready_o = (cnt_q != CntW'(Depth));
  assign rd_valid_o = (cnt_q != '0);
  assign push       = wr_valid_i && wr_ready_o;
  assign pop        = rd_valid_o && rd_ready_i;
  assign rd_data_o  = mem_q[rd_ptr_q];

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

// ----- hw/rtl/rlts_back.sv -----
// back end: walks the register mask and issues one transfer command per cycle while its output slot is free
module rlts_back import rlts_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        req_valid_i,
  output logic        req_ready_o,
  input  req_t        req_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        transfer_valid_o,
  output logic [3:0]  reg_index_o,
  output logic [31:0] mem_address_o,
  output logic        to_memory_o,
  output logic        sign_extend_word_o,
  output logic [31:0] final_address_o,
  output logic        write_back_o,
  output logic        last_o
);

  state_e      state_q, state_d;
  req_t        cur_q, cur_d;
  logic [31:0] addr_q, addr_d;
  logic        out_valid_q, out_valid_d;
  logic        slot_free, emit, pop;
  logic        empty, is_last;
  logic [3:0]  bit_idx;
  logic [15:0] mask_rest;
  logic [31:0] size32, addr_dec, this_addr;

  logic        tv_q, tm_q, se_q, wb_q, last_q;
  logic [3:0]  ri_q;
  logic [31:0] ma_q, fa_q;

  assign slot_free = !out_valid_q || out_ready_i;

  // lowest set bit of the remaining mask
  always_comb begin
    bit_idx = '0;
    for (int i = 15; i >= 0; i--) begin
      if (cur_q.mask[i]) begin
        bit_idx = 4'(i);
      end
    end
  end

  assign mask_rest = cur_q.mask & (cur_q.mask - 16'd1);
  assign empty     = (cur_q.mask == '0);
  assign is_last   = (mask_rest == '0);

  // address of this transfer
  assign size32    = cur_q.is_long ? 32'd4 : 32'd2;
  assign addr_dec  = addr_q - size32;
  assign this_addr = cur_q.predec ? addr_dec : addr_q;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (req_valid_i) begin
          state_d = StBusy;
        end
      end
      StBusy: begin
        if (slot_free && (empty || is_last)) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // state outputs
  always_comb begin
    pop  = 1'b0;
    emit = 1'b0;
    case (state_q)
      StIdle:  pop  = req_valid_i;
      StBusy:  emit = slot_free;
      default: ;
    endcase
  end

  assign req_ready_o = pop;

  // working request and running address
  always_comb begin
    cur_d  = cur_q;
    addr_d = addr_q;
    if (pop) begin
      cur_d  = req_i;
      addr_d = req_i.start;
    end else if (emit && !empty) begin
      cur_d.mask = mask_rest;
      addr_d     = cur_q.predec ? addr_dec : addr_q + size32;
    end
  end

  // output register valid
  always_comb begin
    out_valid_d = out_valid_q;
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    cur_q  <= cur_d;
    addr_q <= addr_d;
    if (emit) begin
      tv_q   <= !empty;
      ri_q   <= empty ? 4'd0 : (cur_q.predec ? 4'd15 - bit_idx : bit_idx);
      ma_q   <= empty ? addr_q : this_addr;
      tm_q   <= cur_q.to_mem;
      se_q   <= empty ? 1'b0 : cur_q.sext;
      fa_q   <= cur_q.final_addr;
      wb_q   <= cur_q.wb && (empty || is_last);
      last_q <= empty || is_last;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign transfer_valid_o   = tv_q;
  assign reg_index_o        = ri_q;
  assign mem_address_o      = ma_q;
  assign to_memory_o        = tm_q;
  assign sign_extend_word_o = se_q;
  assign final_address_o    = fa_q;
  assign write_back_o       = wb_q;
  assign last_o             = last_q;

endmodule

// ----- hw/rtl/register_list_transfer_sequencer.sv -----
// top level of the register list transfer sequencer
// a request passes through the queue into the back end's working register; each command
// is registered in the output slot. The mask walk gives N commands for a request with N
//   list bits (N >= 1, empty list counts as one), one per cycle while the slot is free
// the request queue lets new requests be taken while the back end is busy
// reset: asynchronous active low, clears queue pointers, sequencer state and output valid
module register_list_transfer_sequencer import rlts_pkg::*; #(
  parameter int unsigned QueueDepth = RltsQueueDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  mode_i,
  input  logic        is_long_i,
  input  logic [15:0] reg_mask_i,
  input  logic [31:0] start_address_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        transfer_valid_o,
  output logic [3:0]  reg_index_o,
  output logic [31:0] mem_address_o,
  output logic        to_memory_o,
  output logic        sign_extend_word_o,
  output logic [31:0] final_address_o,
  output logic        write_back_o,
  output logic        last_o
);

  req_t front_req, queue_req;
  logic queue_valid, queue_ready;

  // classify incoming request
  rlts_front u_front (
    .mode_i          (mode_i),
    .is_long_i       (is_long_i),
    .reg_mask_i      (reg_mask_i),
    .start_address_i (start_address_i),
    .req_o           (front_req)
  );

  // decoupling queue
  rlts_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (in_valid_i),
    .wr_ready_o (in_ready_o),
    .wr_data_i  (front_req),
    .rd_valid_o (queue_valid),
    .rd_ready_i (queue_ready),
    .rd_data_o  (queue_req)
  );

  // command sequencer
  rlts_back u_back (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .req_valid_i        (queue_valid),
    .req_ready_o        (queue_ready),
    .req_i              (queue_req),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .transfer_valid_o   (transfer_valid_o),
    .reg_index_o        (reg_index_o),
    .mem_address_o      (mem_address_o),
    .to_memory_o        (to_memory_o),
    .sign_extend_word_o (sign_extend_word_o),
    .final_address_o    (final_address_o),
    .write_back_o       (write_back_o),
    .last_o             (last_o)
  );

endmodule

// ----- tb/sv/testbench.sv -----
// self-checking testbench of the register list transfer sequencer
module testbench;
  import rlts_pkg::*;

  // cycles with no transfer on either side before the run is given up
  localparam int unsigned QuietLimit = 1000;
  // receiver hold-off used to fill the request queue
  localparam int unsigned LongHoldCycles = 150;
  // settling time after the last command
  localparam int unsigned DrainCycles = 12;

  // one transfer command as the block should emit it
  typedef struct {
    logic        transfer_valid;
    logic [3:0]  reg_index;
    logic [31:0] mem_address;
    logic        to_memory;
    logic        sign_extend_word;
    logic [31:0] final_address;
    logic        write_back;
    logic        last;
  } command_t;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [1:0]  mode_i;
  logic        is_long_i;
  logic [15:0] reg_mask_i;
  logic [31:0] start_address_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic        transfer_valid_o;
  logic [3:0]  reg_index_o;
  logic [31:0] mem_address_o;
  logic        to_memory_o;
  logic        sign_extend_word_o;
  logic [31:0] final_address_o;
  logic        write_back_o;
  logic        last_o;

  command_t    awaited_commands[$];
  int unsigned mismatch_count;
  int unsigned commands_seen;
  bit          gaps_enabled;
  bit          long_hold_pending;

  register_list_transfer_sequencer DUT (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .mode_i             (mode_i),
    .is_long_i          (is_long_i),
    .reg_mask_i         (reg_mask_i),
    .start_address_i    (start_address_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .transfer_valid_o   (transfer_valid_o),
    .reg_index_o        (reg_index_o),
    .mem_address_o      (mem_address_o),
    .to_memory_o        (to_memory_o),
    .sign_extend_word_o (sign_extend_word_o),
    .final_address_o    (final_address_o),
    .write_back_o       (write_back_o),
    .last_o             (last_o)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // expand one request into the commands it must produce
  function automatic void expand_register_list(mode_e mode, logic is_long, logic [15:0] mask,
                                               logic [31:0] start);
    logic [31:0] step_bytes;
    logic [31:0] addr;
    logic [31:0] final_addr;
    logic        predec;
    logic        to_mem;
    logic        wb;
    logic        sext;
    int unsigned count;
    int unsigned issued;
    int          b;
    command_t    cmd;
    step_bytes = is_long ? 32'd4 : 32'd2;
    predec = (mode == ModeStorePredec);
    to_mem = (mode == ModeStore) || (mode == ModeStorePredec);
    wb = (mode == ModeStorePredec) || (mode == ModeLoadPostinc);
    sext = !to_mem && !is_long;
    count = $countones(mask);
    final_addr = predec ? start - 32'(count) * step_bytes : start + 32'(count) * step_bytes;
    // empty list: one command that moves nothing
    if (count == 0) begin
      cmd = '{1'b0, 4'd0, start, to_mem, 1'b0, start, wb, 1'b1};
      awaited_commands.push_back(cmd);
      return;
    end
    addr = start;
    issued = 0;
    for (b = 0; b < 16; b++) begin
      if (mask[b]) begin
        issued++;
        cmd.transfer_valid = 1'b1;
        // predecrement walks A7..A0 then D7..D0, address lowered before each store
        if (predec) begin
          addr = addr - step_bytes;
          cmd.mem_address = addr;
          cmd.reg_index = 4'(15 - b);
        end else begin
          cmd.mem_address = addr;
          addr = addr + step_bytes;
          cmd.reg_index = 4'(b);
        end
        cmd.to_memory = to_mem;
        cmd.sign_extend_word = sext;
        cmd.final_address = final_addr;
        cmd.last = (issued == count);
        cmd.write_back = wb && cmd.last;
        awaited_commands.push_back(cmd);
      end
    end
  endfunction

  // one line per mismatch, counted
  task automatic report_mismatch(string msg);
    mismatch_count++;
    $display("[%0t] MISMATCH: %s", $realtime, msg);
  endtask

  task automatic check_field(string field, logic [31:0] got, logic [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("command %0d %s: got %h, expected %h",
                                commands_seen, field, got, want));
  endtask

  // present one request and hold it until the transfer
  task automatic send_request(mode_e mode, logic is_long, logic [15:0] mask,
                              logic [31:0] start);
    int unsigned gap;
    gap = gaps_enabled ? $urandom_range(0, 5) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    mode_i          <= mode;
    is_long_i       <= is_long;
    reg_mask_i      <= mask;
    start_address_i <= start;
    do @(posedge clk_i); while (in_ready_o !== 1'b1);
    expand_register_list(mode, is_long, mask, start);
  endtask

  // command sink: random ready gaps, an occasional long hold-off, field checks
  initial begin : command_sink
    int unsigned wait_cycles;
    command_t    want;
    out_ready_i = 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (long_hold_pending) begin
        long_hold_pending = 1'b0;
        out_ready_i <= 1'b0;
        repeat (LongHoldCycles) @(posedge clk_i);
      end
      wait_cycles = gaps_enabled ? $urandom_range(0, 5) : 0;
      if (wait_cycles > 0) begin
        out_ready_i <= 1'b0;
        repeat (wait_cycles) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (out_valid_o !== 1'b1);
      if (awaited_commands.size() == 0) begin
        report_mismatch($sformatf("command %0d arrived with none expected", commands_seen));
      end else begin
        want = awaited_commands.pop_front();
        check_field("transfer_valid", 32'(transfer_valid_o), 32'(want.transfer_valid));
        check_field("reg_index", 32'(reg_index_o), 32'(want.reg_index));
        check_field("mem_address", mem_address_o, want.mem_address);
        check_field("to_memory", 32'(to_memory_o), 32'(want.to_memory));
        check_field("sign_extend_word", 32'(sign_extend_word_o), 32'(want.sign_extend_word));
        check_field("final_address", final_address_o, want.final_address);
        check_field("write_back", 32'(write_back_o), 32'(want.write_back));
        check_field("last", 32'(last_o), 32'(want.last));
      end
      commands_seen++;
    end
  end

  // watchdog on cycles without any transfer
  initial begin : watchdog
    int unsigned quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < QuietLimit) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("Test completed with failures");
    $finish;
  end

  // empty lists in every mode, full lists in every mode and size, single bits and address wrap
  task automatic test_corner_requests();
    int m;
    gaps_enabled = 1'b1;
    for (m = 0; m < 4; m++)
      send_request(mode_e'(m), m[0], 16'h0000, (m < 2) ? 32'h0000_0000 : 32'hFFFF_FFFF);
    for (m = 0; m < 8; m++)
      send_request(mode_e'(m >> 1), m[0], 16'hFFFF,
                   (mode_e'(m >> 1) == ModeStorePredec) ? 32'h0000_0000 : 32'hFFFF_FFF0);
    send_request(ModeStorePredec, 1'b1, 16'h0001, 32'h0000_0002);
    send_request(ModeStorePredec, 1'b0, 16'h8000, 32'h0000_0001);
    send_request(ModeLoad, 1'b0, 16'h8000, 32'hFFFF_FFFE);
    send_request(ModeLoadPostinc, 1'b1, 16'h0001, 32'hFFFF_FFFC);
    send_request(ModeStore, 1'b0, 16'hAAAA, 32'h8000_0000);
    send_request(ModeLoadPostinc, 1'b0, 16'h5555, 32'h7FFF_FFFF);
    send_request(ModeStorePredec, 1'b1, 16'h00FF, 32'h1234_5678);
    send_request(ModeLoad, 1'b1, 16'hFF00, 32'hDEAD_BEEF);
  endtask

  // random requests in stretches with and without idle gaps
  task automatic test_random_requests(int unsigned count);
    int unsigned i;
    mode_e       mode;
    logic [15:0] mask;
    logic [31:0] start;
    for (i = 0; i < count; i++) begin
      if (i % 40 == 0) gaps_enabled = ($urandom_range(0, 3) != 0);
      mode = mode_e'($urandom_range(0, 3));
      case ($urandom_range(0, 7))
        0: mask = 16'h0000;
        1: mask = 16'hFFFF;
        2: mask = 16'(1 << $urandom_range(0, 15));
        3: mask = 16'($urandom) & 16'($urandom);
        default: mask = 16'($urandom);
      endcase
      // bias some starts toward both ends so the address wraps
      case ($urandom_range(0, 5))
        0: start = 32'($urandom_range(0, 63));
        1: start = 32'hFFFF_FFFF - 32'($urandom_range(0, 63));
        default: start = $urandom;
      endcase
      send_request(mode, 1'($urandom_range(0, 1)), mask, start);
    end
    gaps_enabled = 1'b1;
  endtask

  // receiver holds off while requests keep coming, so the queue fills and stalls
  task automatic test_output_backpressure();
    int unsigned i;
    gaps_enabled = 1'b0;
    long_hold_pending = 1'b1;
    for (i = 0; i < 30; i++)
      send_request(mode_e'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                   16'($urandom) & 16'($urandom) & 16'($urandom), $urandom);
    gaps_enabled = 1'b1;
  endtask

  // reset, tests in turn, drain, verdict
  initial begin
    rst_ni            = 1'b0;
    in_valid_i        = 1'b0;
    mode_i            = '0;
    is_long_i         = 1'b0;
    reg_mask_i        = '0;
    start_address_i   = '0;
    mismatch_count    = 0;
    commands_seen     = 0;
    gaps_enabled      = 1'b1;
    long_hold_pending = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_corner_requests();
    test_random_requests(420);
    test_output_backpressure();
    in_valid_i <= 1'b0;
    while (awaited_commands.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
